// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
// No dependencies; define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ===== rtl/dbf_pkg.sv =====
// Types and constants for the deletable Bloom filter.
// No dependencies.
`default_nettype none
package dbf_pkg;
  localparam logic [2:0] KIND_TEST     = 3'd0;
  localparam logic [2:0] KIND_ADD      = 3'd1;
  localparam logic [2:0] KIND_TADD     = 3'd2;
  localparam logic [2:0] KIND_TREMOVE  = 3'd3;
  localparam logic [2:0] KIND_CLEAR    = 3'd4;

  localparam logic [1:0] CFG_BUCKETS = 2'd0;
  localparam logic [1:0] CFG_REGION  = 2'd1;
  localparam logic [1:0] CFG_HASHES  = 2'd2;

  localparam logic [31:0] C1 = 32'hcc9e2d51;
  localparam logic [31:0] C2 = 32'h1b873593;
  localparam logic [31:0] F1 = 32'h85ebca6b;
  localparam logic [31:0] F2 = 32'hc2b2ae35;
  localparam logic [31:0] HADD = 32'he6546b64;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] key;
    logic [3:0]  key_bytes;
  } in_t;

  typedef struct packed {
    logic        member;
    logic [31:0] item_count;
  } out_t;
endpackage
`default_nettype wire

// ===== rtl/dbf_divu.sv =====
// Restoring divider, one quotient bit per cycle (remainder and quotient).
// Depends on nothing; used for hash modulo and region index.
`default_nettype none
module dbf_divu #(
  parameter int W = 32,
  parameter int DW = 13
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [W-1:0]  dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [W-1:0]       quotient,
  output logic [DW-1:0]      remainder
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0]  q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [DW+1:0] trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r, q_r[W-1]} - {2'b00, d_r};
    if (start) begin
      q_nxt = dividend; rem_nxt = '0; d_nxt = divisor;
      cnt_nxt = CW'(W); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DW+1]) begin
        rem_nxt = trial[DW:0];
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DW-1:0], q_r[W-1]};
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt;
  end

  assign done = done_r;
  assign quotient = q_r;
  assign remainder = rem_r[DW-1:0];
endmodule
`default_nettype wire

// ===== rtl/deletable_bloom_filter.sv =====
// Deletable Bloom filter top: sequencer, shared hash multiplier, divider, bit memories.
// Depends on dbf_pkg, dbf_divu and assert_macros.svh.
// Per hash: hash the key (more rounds for longer keys), take the modulo on the bit-serial
//   divider, then read its bucket bit. Add and removal of a member rerun every hash, each
//   plus a region divide and write.
// One transaction at a time. Reset and clear requests run a clearing pass over both
//   bit memories.
`default_nettype none
`include "assert_macros.svh"
module deletable_bloom_filter #(
  parameter int MAX_BUCKETS = 4096,
  parameter int NUM_REGIONS = 64,
  parameter int MAX_HASHES  = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire dbf_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output dbf_pkg::out_t       out_data,
  input  wire logic           cfg_we,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [12:0]    cfg_data
);
  localparam int BW = $clog2(MAX_BUCKETS);
  localparam int RW = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
  localparam int HW = $clog2(MAX_HASHES + 1);
  localparam int CLR_N = (MAX_BUCKETS > NUM_REGIONS) ? MAX_BUCKETS : NUM_REGIONS;
  localparam int CLRW = $clog2(CLR_N);

  localparam logic [4:0] S_CLR = 5'd0, S_IDLE = 5'd1, S_HBLK = 5'd2, S_M1 = 5'd3,
    S_M2 = 5'd4, S_M3 = 5'd5, S_TAIL = 5'd6, S_F1 = 5'd7, S_F2 = 5'd8,
    S_F3 = 5'd9, S_MOD = 5'd10, S_RD = 5'd11, S_RDW = 5'd12,
    S_REG = 5'd13, S_WR = 5'd14, S_OUT = 5'd15, S_PH2 = 5'd16, S_MODW = 5'd17,
    S_REGW = 5'd18;

  logic [12:0] bcnt_r, rsize_r;
  logic [4:0]  hcnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcnt_r <= 13'd4096; rsize_r <= 13'd64; hcnt_r <= 5'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        dbf_pkg::CFG_BUCKETS: bcnt_r <= cfg_data;
        dbf_pkg::CFG_REGION:  rsize_r <= cfg_data;
        dbf_pkg::CFG_HASHES:  hcnt_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  logic [12:0] eff_b, eff_rs;
  logic [HW-1:0] eff_h;
  always_comb begin
    if (bcnt_r == '0) eff_b = 13'd1;
    else if ({19'd0, bcnt_r} > MAX_BUCKETS) eff_b = 13'(MAX_BUCKETS);
    else eff_b = bcnt_r;
    eff_rs = (rsize_r == '0) ? 13'd1 : rsize_r;
    if (hcnt_r == '0) eff_h = HW'(1);
    else if ({27'd0, hcnt_r} > MAX_HASHES) eff_h = HW'(MAX_HASHES);
    else eff_h = HW'(hcnt_r);
  end

  logic [4:0]      st_r, st_nxt;
  dbf_pkg::in_t    req_r, req_nxt;
  logic [3:0]      len_r, len_nxt;
  logic [HW-1:0]   seed_r, seed_nxt;
  logic            blk_r, blk_nxt, tail_r, tail_nxt;
  logic [31:0]     h_r, h_nxt, k_r, k_nxt;
  logic            member_r, member_nxt, ph2_r, ph2_nxt;
  logic [31:0]     items_r, items_nxt;
  logic [BW-1:0]   idx_r, idx_nxt;
  logic [CLRW-1:0] clr_r, clr_nxt;
  logic            clr_done;

  logic          bmem [MAX_BUCKETS];
  logic          bit_rd_r;
  logic          regc_mem [NUM_REGIONS];
  logic          regc_rd_r;
  logic [RW-1:0] reg_idx;

  // shared multiplier
  logic [31:0] mul_a, mul_b, mul_p;
  assign mul_p = mul_a * mul_b;

  logic          dv_start, dv_done;
  logic [31:0]   dv_a, dv_q;
  logic [12:0]   dv_d, dv_rem;
  dbf_divu #(.W(32), .DW(13)) u_div (
    .clk, .rst_n, .start(dv_start), .dividend(dv_a), .divisor(dv_d),
    .done(dv_done), .quotient(dv_q), .remainder(dv_rem));

  // tail bytes follow the whole 4-byte blocks
  logic [31:0] tail_k;
  always_comb begin
    tail_k = '0;
    for (int j = 0; j < 4; j++)
      if (j < int'(len_r[1:0])) tail_k[8*j +: 8] = req_r.key[8*(4*int'(len_r[2])+j) +: 8];
  end

  // block round: rotl(h ^ k, 13) * 5 + constant
  logic [31:0] hb, h_rot, h_blk;
  assign hb = h_r ^ k_r;
  assign h_rot = {hb[18:0], hb[31:19]};
  assign h_blk = {h_rot[29:0], 2'b00} + h_rot + dbf_pkg::HADD;

  logic bucket_w_en, bucket_w_val, regc_set;
  logic last_h;
  assign last_h = (seed_r == eff_h - HW'(1));
  assign clr_done = (clr_r == CLRW'(CLR_N - 1));

  always_comb begin
    st_nxt = st_r; req_nxt = req_r; len_nxt = len_r; seed_nxt = seed_r;
    blk_nxt = blk_r; tail_nxt = tail_r; h_nxt = h_r; k_nxt = k_r;
    member_nxt = member_r; ph2_nxt = ph2_r; items_nxt = items_r; idx_nxt = idx_r;
    clr_nxt = clr_r;
    mul_a = k_r; mul_b = dbf_pkg::C1;
    dv_start = 1'b0; dv_a = h_r; dv_d = eff_b;
    bucket_w_en = 1'b0; bucket_w_val = 1'b0; regc_set = 1'b0;
    case (st_r)
      S_CLR: begin
        clr_nxt = clr_r + CLRW'(1);
        if (clr_done) begin
          clr_nxt = '0;
          st_nxt = (req_r.kind == dbf_pkg::KIND_CLEAR) ? S_OUT : S_IDLE;
        end
      end
      S_IDLE: if (in_valid) begin
        req_nxt = in_data;
        len_nxt = (in_data.key_bytes > 4'd8) ? 4'd8 : in_data.key_bytes;
        member_nxt = (in_data.kind <= dbf_pkg::KIND_TREMOVE);
        ph2_nxt = 1'b0; seed_nxt = '0;
        if (in_data.kind <= dbf_pkg::KIND_TREMOVE) st_nxt = S_HBLK;
        else if (in_data.kind == dbf_pkg::KIND_CLEAR) begin
          st_nxt = S_CLR; items_nxt = '0;
        end else st_nxt = S_OUT;
      end
      S_HBLK: begin
        h_nxt = 32'(seed_r);
        k_nxt = req_r.key[31:0];
        blk_nxt = 1'b0; tail_nxt = 1'b0;
        st_nxt = (len_r >= 4'd4) ? S_M1 : S_TAIL;
      end
      S_M1: begin k_nxt = mul_p; st_nxt = S_M2; end
      S_M2: begin mul_a = {k_r[16:0], k_r[31:17]}; mul_b = dbf_pkg::C2;
        k_nxt = mul_p; st_nxt = S_M3; end
      S_M3: begin
        if (tail_r) begin
          h_nxt = hb ^ 32'(len_r); st_nxt = S_F1;
        end else begin
          h_nxt = h_blk;
          if (!blk_r && len_r == 4'd8) begin
            blk_nxt = 1'b1; k_nxt = req_r.key[63:32]; st_nxt = S_M1;
          end else begin
            st_nxt = S_TAIL;
          end
        end
      end
      S_TAIL: begin
        if (len_r[1:0] != 2'd0) begin
          k_nxt = tail_k; tail_nxt = 1'b1; st_nxt = S_M1;
        end else begin
          h_nxt = h_r ^ 32'(len_r); st_nxt = S_F1;
        end
      end
      S_F1: begin mul_a = h_r ^ (h_r >> 16); mul_b = dbf_pkg::F1; h_nxt = mul_p;
        st_nxt = S_F2; end
      S_F2: begin mul_a = h_r ^ (h_r >> 13); mul_b = dbf_pkg::F2; h_nxt = mul_p;
        st_nxt = S_F3; end
      S_F3: begin h_nxt = h_r ^ (h_r >> 16); st_nxt = S_MOD; end
      S_MOD: begin dv_start = 1'b1; st_nxt = S_MODW; end
      S_MODW: if (dv_done) begin idx_nxt = BW'(dv_rem); st_nxt = S_RD; end
      S_RD: st_nxt = S_RDW;
      S_RDW: begin
        if (!ph2_r) begin
          if (!bit_rd_r) member_nxt = 1'b0;
          if (last_h) begin
            if (req_r.kind == dbf_pkg::KIND_ADD || req_r.kind == dbf_pkg::KIND_TADD ||
                (req_r.kind == dbf_pkg::KIND_TREMOVE && member_nxt))
              st_nxt = S_PH2;
            else st_nxt = S_OUT;
          end else begin
            seed_nxt = seed_r + HW'(1); st_nxt = S_HBLK;
          end
        end else begin
          st_nxt = S_REG;
        end
      end
      S_PH2: begin ph2_nxt = 1'b1; seed_nxt = '0; st_nxt = S_HBLK; end
      S_REG: begin dv_start = 1'b1; dv_a = 32'(idx_r); dv_d = eff_rs;
        st_nxt = S_REGW; end
      S_REGW: if (dv_done) st_nxt = S_WR;
      S_WR: begin
        if (req_r.kind == dbf_pkg::KIND_TREMOVE) begin
          bucket_w_en = !regc_rd_r;
        end else begin
          bucket_w_en = !bit_rd_r; bucket_w_val = 1'b1; regc_set = bit_rd_r;
        end
        if (last_h) begin
          st_nxt = S_OUT;
          if (req_r.kind == dbf_pkg::KIND_TREMOVE)
            items_nxt = (items_r != '0) ? items_r - 32'd1 : items_r;
          else
            items_nxt = (items_r != '1) ? items_r + 32'd1 : items_r;
        end else begin
          seed_nxt = seed_r + HW'(1); st_nxt = S_HBLK;
        end
      end
      S_OUT: if (!out_stall) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // region index from divider quotient, clamped to the last region
  always_comb begin
    if (dv_q >= 32'(NUM_REGIONS)) reg_idx = RW'(NUM_REGIONS - 1);
    else reg_idx = RW'(dv_q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; items_r <= '0; ph2_r <= 1'b0; req_r <= '0;
      len_r <= '0; seed_r <= '0; blk_r <= 1'b0; tail_r <= 1'b0;
      h_r <= '0; k_r <= '0; member_r <= 1'b0; idx_r <= '0;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt; items_r <= items_nxt; ph2_r <= ph2_nxt;
      req_r <= req_nxt; len_r <= len_nxt; seed_r <= seed_nxt; blk_r <= blk_nxt;
      tail_r <= tail_nxt; h_r <= h_nxt; k_r <= k_nxt; member_r <= member_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_CLR) begin
      if (int'(clr_r) < MAX_BUCKETS) bmem[BW'(clr_r)] <= 1'b0;
    end else if (bucket_w_en) bmem[idx_r] <= bucket_w_val;
    bit_rd_r <= bmem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (st_r == S_CLR) begin
      if (int'(clr_r) < NUM_REGIONS) regc_mem[RW'(clr_r)] <= 1'b0;
    end else if (regc_set) regc_mem[reg_idx] <= 1'b1;
    regc_rd_r <= regc_mem[reg_idx];
  end

  assign in_stall = (st_r != S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_data.member = member_r && req_r.kind <= dbf_pkg::KIND_TREMOVE;
  assign out_data.item_count = items_r;

  logic clr_req;
  assign clr_req = (st_r == S_CLR) && (req_r.kind == dbf_pkg::KIND_CLEAR);

  `ASSERT_NEVER(a_out_idle, clk, rst_n, out_valid && !in_stall, "out_valid while idle")
  `ASSERT_IMPL(a_cnt_hold, clk, rst_n, (out_valid && out_stall) |=> $stable(out_data), "moved")
  `ASSERT_IMPL(a_clr_cnt, clk, rst_n, clr_req |-> (items_r == '0), "clear left count")
endmodule
`default_nettype wire
